/* rtl/core/ilp_pkg.sv */
// Shared types, constants and the CRC-32 word step for the image load engine.
package ilp_pkg;

	localparam int unsigned PAGE_BYTES = 256;
	localparam int unsigned PAGE_W     = $clog2(PAGE_BYTES);

	localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
	localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [31:0] MAGIC_WORD = 32'h4650_5455;
	localparam logic [15:0] HDR_BYTES  = 16'h0020;
	localparam logic [15:0] HDR_VER    = 16'h0001;
	localparam logic [31:0] FAIL_WORD  = 32'hDEAD_BEEF;
	localparam logic [31:0] FLASH_BASE = 32'h0800_0000;
	localparam logic [31:0] WORD_BYTES = 32'd4;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic        send_valid;
		logic [31:0] send_value;
		logic        write_valid;
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic        page_start;
		logic        done_res;
		logic        success;
	} res_t;

	// MSB-first CRC-32 over the four bytes of a word, lowest byte first.
	// Linear in its inputs, so this flattens to an XOR network.
	function automatic logic [31:0] crc_word(input logic [31:0] crc_in,
	                                         input logic [31:0] w);
		logic [31:0] c;
		c = crc_in;
		for (int b = 0; b < 4; b++) begin
			c = c ^ {w[8*b +: 8], 24'd0};
			for (int i = 0; i < 8; i++) begin
				c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/core/image_load_protocol_top.sv */
// Top level of the boot image loader: input stage, engine and result register.
//
// Each accepted word (a start or a host reply) yields exactly one result word:
// the word is held in the input stage, where the engine updates the session
// state with a single word-wide CRC step, and its result is then registered
// in the result register. A new word is accepted every cycle while the result
// side keeps up; item_stall rises only when the result register is full and
// res_stall holds it. A session is a start word, eight header replies, then
// one reply per payload word (header word 2 divided by four); the last word
// returns status 0xFFFFFFFF (accepted) or 0xDEADBEEF (rejected) with done_res set.
module image_load_protocol_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [31:0] reply_word,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        send_valid,
	output logic [31:0] send_value,
	output logic        write_valid,
	output logic [31:0] write_address,
	output logic [31:0] write_data,
	output logic        page_start,
	output logic        done_res,
	output logic        success
);
	import ilp_pkg::*;

	logic        valid_s1;
	logic        kind_s1;
	logic [31:0] word_s1;
	logic        advance;
	logic        fire;
	res_t        res;
	logic        res_valid_q;
	res_t        res_q;

	assign advance    = !res_valid_q || !res_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			kind_s1 <= kind;
			word_s1 <= reply_word;
		end
		if (fire) begin
			res_q <= res;
		end
	end

	ilp_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.kind   (kind_s1),
		.word   (word_s1),
		.res    (res)
	);

	assign res_valid     = res_valid_q;
	assign send_valid    = res_q.send_valid;
	assign send_value    = res_q.send_value;
	assign write_valid   = res_q.write_valid;
	assign write_address = res_q.write_address;
	assign write_data    = res_q.write_data;
	assign page_start    = res_q.page_start;
	assign done_res      = res_q.done_res;
	assign success       = res_q.success;

	a_write_sends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.write_valid |-> res_q.send_valid)
		else $error("payload write without a word to the host");
	a_success_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.success |-> res_q.done_res && res_q.send_valid)
		else $error("success outside the end of a session");
	a_page_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.page_start |-> res_q.write_valid)
		else $error("page start without a flash write");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("input stalled with room in the pipeline");

endmodule

/* rtl/core/ilp_engine.sv */
// Session state, header checks and payload sequencing for one word per cycle while fire is high.
module ilp_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic        kind,
	input  logic [31:0] word,
	output ilp_pkg::res_t res
);
	import ilp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [29:0] cnt_q, cnt_d;
	logic [31:0] hdr_q [8];
	logic [31:0] hcrc_q, hcrc_d;
	logic [31:0] pcrc_q, pcrc_d;
	logic [31:0] rd_addr_q, rd_addr_d;
	logic [31:0] wr_addr_q, wr_addr_d;

	logic [2:0]  hk;
	logic [2:0]  hk_next;
	logic [31:0] crc_new;
	logic        hdr_ok;
	logic        psize_zero;
	logic [30:0] k_next;
	logic        last_word;
	logic        pay_ok;
	logic [31:0] offset;
	logic        page_hit;

	assign hk      = cnt_q[2:0];
	assign hk_next = hk + 3'd1;

	// one CRC unit, shared: header and payload never run together
	assign crc_new = crc_word((phase_q == PH_PAYLOAD) ? pcrc_q : hcrc_q, word);

	assign hdr_ok = (hdr_q[0] == MAGIC_WORD) && (hdr_q[1][15:0] == HDR_VER) &&
		(hdr_q[1][31:16] == HDR_BYTES) && (hdr_q[2][1:0] == 2'b00) &&
		((hdr_q[5][31:16] != 16'd0) || ((hcrc_q ^ ALL_ONES) == hdr_q[6]));
	assign psize_zero = (hdr_q[2] == 32'd0);

	assign k_next    = {1'b0, cnt_q} + 31'd1;
	assign last_word = k_next >= {1'b0, hdr_q[2][31:2]};
	assign pay_ok    = (crc_new ^ ALL_ONES) == hdr_q[7];
	assign offset    = {cnt_q, 2'b00};
	assign page_hit  = (offset[PAGE_W-1:0] == '0);

	// next state
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		hcrc_d    = hcrc_q;
		pcrc_d    = pcrc_q;
		rd_addr_d = rd_addr_q;
		wr_addr_d = wr_addr_q;
		if (kind == KIND_START) begin
			phase_d = PH_HEADER;
			cnt_d   = '0;
			hcrc_d  = ALL_ONES;
			pcrc_d  = ALL_ONES;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (hk < 3'd6) begin
						hcrc_d = crc_new;
					end
					if (hk != 3'd7) begin
						cnt_d = {27'd0, hk_next};
					end else if (!hdr_ok) begin
						phase_d = PH_IDLE;
					end else begin
						pcrc_d    = ALL_ONES;
						cnt_d     = '0;
						rd_addr_d = hdr_q[3];
						wr_addr_d = hdr_q[3] | FLASH_BASE;
						phase_d   = psize_zero ? PH_IDLE : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					pcrc_d    = crc_new;
					rd_addr_d = rd_addr_q + WORD_BYTES;
					wr_addr_d = wr_addr_q + WORD_BYTES;
					if (last_word) begin
						phase_d = PH_IDLE;
					end else begin
						cnt_d = k_next[29:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result word
	always_comb begin
		res = '0;
		if (kind == KIND_START) begin
			res.send_valid = 1'b1;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					res.send_valid = 1'b1;
					if (hk != 3'd7) begin
						res.send_value = {27'd0, hk_next, 2'b00};
					end else if (!hdr_ok) begin
						res.send_value = FAIL_WORD;
						res.done_res   = 1'b1;
					end else if (psize_zero) begin
						// empty payload: its CRC is zero
						res.done_res   = 1'b1;
						res.success    = (word == 32'd0);
						res.send_value = (word == 32'd0) ? ALL_ONES : FAIL_WORD;
					end else begin
						res.send_value = hdr_q[3];
					end
				end
				PH_PAYLOAD: begin
					res.send_valid    = 1'b1;
					res.write_valid   = 1'b1;
					res.write_address = wr_addr_q;
					res.write_data    = word;
					res.page_start    = page_hit;
					if (last_word) begin
						res.done_res   = 1'b1;
						res.success    = pay_ok;
						res.send_value = pay_ok ? ALL_ONES : FAIL_WORD;
					end else begin
						res.send_value = rd_addr_q + WORD_BYTES;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			hcrc_q  <= ALL_ONES;
			pcrc_q  <= ALL_ONES;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			hcrc_q  <= hcrc_d;
			pcrc_q  <= pcrc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_addr_q <= rd_addr_d;
			wr_addr_q <= wr_addr_d;
			if (kind == KIND_REPLY && phase_q == PH_HEADER) begin
				hdr_q[hk] <= word;
			end
		end
	end

	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> cnt_q[29:3] == '0)
		else $error("header word count out of range");
	a_pay_addr: assert property (@(posedge clk) disable iff (!arst_n)
		fire && kind == KIND_REPLY && phase_q == PH_PAYLOAD && !last_word
		|=> rd_addr_q == $past(rd_addr_q) + WORD_BYTES)
		else $error("payload read address did not step by one word");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		fire && kind == KIND_START |=> phase_q == PH_HEADER && cnt_q == '0)
		else $error("start word did not open a header session");

endmodule

/* sim/image_load_protocol_top_test.sv */
// Self-checking testbench for the boot image loader: sessions in, host and flash words out.
module image_load_protocol_top_test;
	import ilp_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG    = 5000;
	localparam int PHASE_ITEMS = 375;

	typedef enum int {
		FLAW_NONE    = 0,
		FLAW_MAGIC   = 1,
		FLAW_VERSION = 2,
		FLAW_HSIZE   = 3,
		FLAW_PSIZE   = 4,
		FLAW_HCRC    = 5,
		FLAW_PCRC    = 6,
		FLAW_BYPASS  = 7
	} flaw_t;

	// Tracks the loader session and queues the word the block owes for each accepted input.
	class loader_scoreboard;
		phase_t      ph;
		logic [29:0] wcnt;
		logic [31:0] hdr[8];
		logic [31:0] hcrc;
		logic [31:0] pcrc;
		res_t        due_q[$];
		int          errors;

		function new();
			ph = PH_IDLE;
			wcnt = '0;
			hcrc = ALL_ONES;
			pcrc = ALL_ONES;
			errors = 0;
		endfunction

		// bit-serial, MSB first, bytes taken lowest first
		function logic [31:0] crc_step(logic [31:0] c, logic [31:0] w);
			logic [31:0] r;
			logic        fb;
			r = c;
			for (int b = 0; b < 4; b++) begin
				for (int i = 7; i >= 0; i--) begin
					fb = r[31] ^ w[8*b+i];
					r = {r[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'd0);
				end
			end
			return r;
		endfunction

		function res_t with_status(res_t r, logic ok);
			r.send_valid = 1'b1;
			r.send_value = ok ? ALL_ONES : FAIL_WORD;
			r.done_res = 1'b1;
			r.success = ok;
			ph = PH_IDLE;
			return r;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void take_word(logic k, logic [31:0] w);
			res_t        r;
			logic [2:0]  idx;
			logic [31:0] off;
			logic        ok;
			r = '0;
			if (k == KIND_START) begin
				ph = PH_HEADER;
				wcnt = '0;
				hcrc = ALL_ONES;
				pcrc = ALL_ONES;
				r.send_valid = 1'b1;
			end else if (ph == PH_HEADER) begin
				idx = wcnt[2:0];
				hdr[idx] = w;
				if (idx < 3'd6)
					hcrc = crc_step(hcrc, w);
				if (idx < 3'd7) begin
					wcnt = 30'(idx) + 30'd1;
					r.send_valid = 1'b1;
					r.send_value = (32'(idx) + 32'd1) << 2;
				end else begin
					ok = hdr[0] == MAGIC_WORD && hdr[1][15:0] == HDR_VER &&
						hdr[1][31:16] == HDR_BYTES && hdr[2][1:0] == 2'b00;
					if (ok && hdr[5][31:16] == 16'd0)
						ok = (hcrc ^ ALL_ONES) == hdr[6];
					if (!ok) begin
						r = with_status(r, 1'b0);
					end else begin
						pcrc = ALL_ONES;
						wcnt = '0;
						if (hdr[2] == 32'd0) begin
							r = with_status(r, hdr[7] == 32'd0);
						end else begin
							ph = PH_PAYLOAD;
							r.send_valid = 1'b1;
							r.send_value = hdr[3];
						end
					end
				end
			end else if (ph == PH_PAYLOAD) begin
				off = {wcnt, 2'b00};
				r.write_valid = 1'b1;
				r.write_address = (hdr[3] | FLASH_BASE) + off;
				r.write_data = w;
				r.page_start = (off % PAGE_BYTES) == 0;
				pcrc = crc_step(pcrc, w);
				if ({2'b00, wcnt} + 32'd1 >= {2'b00, hdr[2][31:2]}) begin
					r = with_status(r, (pcrc ^ ALL_ONES) == hdr[7]);
				end else begin
					wcnt = wcnt + 30'd1;
					r.send_valid = 1'b1;
					r.send_value = hdr[3] + off + 32'd4;
				end
			end
			due_q.push_back(r);
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h want %h", field, got, want);
			errors++;
		endtask

		task check_result(res_t got);
			res_t e;
			if (due_q.size() == 0) begin
				report("unexpected word", 32'(got.send_value), 32'd0);
			end else begin
				e = due_q.pop_front();
				if (got.send_valid !== e.send_valid)
					report("send_valid", 32'(got.send_valid), 32'(e.send_valid));
				if (got.send_value !== e.send_value)
					report("send_value", got.send_value, e.send_value);
				if (got.write_valid !== e.write_valid)
					report("write_valid", 32'(got.write_valid), 32'(e.write_valid));
				if (got.write_address !== e.write_address)
					report("write_address", got.write_address, e.write_address);
				if (got.write_data !== e.write_data)
					report("write_data", got.write_data, e.write_data);
				if (got.page_start !== e.page_start)
					report("page_start", 32'(got.page_start), 32'(e.page_start));
				if (got.done_res !== e.done_res)
					report("done_res", 32'(got.done_res), 32'(e.done_res));
				if (got.success !== e.success)
					report("success", 32'(got.success), 32'(e.success));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        kind = KIND_START;
	logic [31:0] reply_word = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        send_valid;
	logic [31:0] send_value;
	logic        write_valid;
	logic [31:0] write_address;
	logic [31:0] write_data;
	logic        page_start;
	logic        done_res;
	logic        success;

	loader_scoreboard sb = new();

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_asks = 0;
	int holds_served = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int items_done = 0;

	image_load_protocol_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.reply_word(reply_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.send_valid(send_valid),
		.send_value(send_value),
		.write_valid(write_valid),
		.write_address(write_address),
		.write_data(write_data),
		.page_start(page_start),
		.done_res(done_res),
		.success(success)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check accepted words, then pick the next stall value
	always @(posedge clk) begin
		if (res_valid && !res_stall)
			sb.check_result({send_valid, send_value, write_valid, write_address,
				write_data, page_start, done_res, success});
		if (hold_asks != holds_served) begin
			holds_served++;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAIL image_load_protocol_top");
			$finish;
		end
	end

	task automatic put_word(logic k, logic [31:0] w);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		reply_word <= w;
		do @(posedge clk); while (item_stall);
		sb.take_word(k, w);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// start word, eight header words, then the payload if the header should pass;
	// cut >= 0 stops after that many replies so a later start abandons the session
	task automatic image_session(int n_words, flaw_t flaw, int cut, logic [31:0] base);
		logic [31:0] hdr_w[8];
		logic [31:0] body[$];
		logic [31:0] c;
		int          budget;
		logic        hdr_ok;
		budget = (cut < 0) ? 32'h4000_0000 : cut;
		for (int i = 0; i < n_words; i++)
			body.push_back($urandom());
		hdr_w[0] = MAGIC_WORD;
		hdr_w[1] = {HDR_BYTES, HDR_VER};
		hdr_w[2] = 32'(n_words) << 2;
		hdr_w[3] = base;
		hdr_w[4] = $urandom();
		hdr_w[5] = {16'd0, 16'($urandom())};
		case (flaw)
			FLAW_MAGIC:   hdr_w[0] = MAGIC_WORD ^ $urandom_range(1, 32'hFFFF_FFFF);
			FLAW_VERSION: hdr_w[1][15:0] = HDR_VER ^ 16'($urandom_range(1, 65535));
			FLAW_HSIZE:   hdr_w[1][31:16] = HDR_BYTES ^ 16'($urandom_range(1, 65535));
			FLAW_PSIZE:   hdr_w[2][1:0] = 2'($urandom_range(1, 3));
			FLAW_BYPASS:  hdr_w[5][31:16] = 16'($urandom_range(1, 65535));
			default: ;
		endcase
		c = ALL_ONES;
		for (int i = 0; i < 6; i++)
			c = sb.crc_step(c, hdr_w[i]);
		hdr_w[6] = ~c;
		if (flaw == FLAW_HCRC)
			hdr_w[6] ^= $urandom_range(1, 32'hFFFF_FFFF);
		if (flaw == FLAW_BYPASS)
			hdr_w[6] = $urandom();
		c = ALL_ONES;
		foreach (body[i])
			c = sb.crc_step(c, body[i]);
		hdr_w[7] = ~c;
		if (flaw == FLAW_PCRC)
			hdr_w[7] ^= $urandom_range(1, 32'hFFFF_FFFF);
		hdr_ok = flaw == FLAW_NONE || flaw == FLAW_PCRC || flaw == FLAW_BYPASS;

		put_word(KIND_START, $urandom());
		items_done++;
		for (int i = 0; i < 8 && budget > 0; i++) begin
			put_word(KIND_REPLY, hdr_w[i]);
			items_done++;
			budget--;
		end
		if (hdr_ok) begin
			for (int i = 0; i < n_words && budget > 0; i++) begin
				put_word(KIND_REPLY, body[i]);
				items_done++;
				budget--;
			end
		end
	endtask

	initial begin
		int    tx_pct[4];
		int    rx_pct[4];
		int    goal;
		int    n;
		int    cut;
		flaw_t flaw;
		logic [31:0] base;
		tx_pct = '{0, 57, 0, 34};
		rx_pct = '{0, 0, 57, 34};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// replies with no session open, a start that gets abandoned,
		// an empty payload, and a payload whose addresses wrap past the top
		put_word(KIND_REPLY, 32'hFFFF_FFFF);
		put_word(KIND_REPLY, 32'h0000_0000);
		put_word(KIND_START, 32'hFFFF_FFFF);
		image_session(0, FLAW_NONE, -1, $urandom());
		image_session(3, FLAW_NONE, -1, 32'hFFFF_FFF8);
		drain();

		for (int p = 0; p < 4; p++) begin
			tx_idle_pct = tx_pct[p];
			rx_stall_pct = rx_pct[p];
			if (p == 0)
				hold_asks++;
			goal = items_done + PHASE_ITEMS;
			while (items_done < goal) begin
				if ($urandom_range(5) == 0)
					repeat ($urandom_range(1, 3)) put_word(KIND_REPLY, $urandom());
				n = ($urandom_range(9) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 12);
				flaw = ($urandom_range(99) < 60) ? FLAW_NONE : flaw_t'($urandom_range(1, 7));
				cut = ($urandom_range(9) == 0) ? $urandom_range(0, 8 + n) : -1;
				base = ($urandom_range(7) == 0) ? (32'hFFFF_FE00 | $urandom_range(0, 511))
					: $urandom();
				image_session(n, flaw, cut, base);
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS image_load_protocol_top");
		end else begin
			$display("FAIL image_load_protocol_top");
		end
		$finish;
	end

endmodule
